// ----- src/pfm_pkg.sv -----
// Package of the paging frame manager: sizes, opcodes, status codes and register indexes.
// No dependencies.
`default_nettype none
package pfm_pkg;
   localparam int FRAMES = 64;
   localparam int VPAGES = 1024;
   localparam int FW = $clog2(FRAMES);
   localparam int VW = $clog2(VPAGES);
   localparam logic [1:0] OP_ALLOC    = 2'd0;
   localparam logic [1:0] OP_FREE     = 2'd1;
   localparam logic [1:0] OP_RESIDENT = 2'd2;
   localparam logic [1:0] OP_MODIFY   = 2'd3;
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_PAGE = 2'd1;
   localparam logic [1:0] ST_NO_FRAME = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;
   localparam logic CSR_FRAMES = 1'b0;
   localparam logic CSR_VPAGES = 1'b1;
   typedef struct packed {
      logic [1:0]    status;
      logic [VW-1:0] vpage_out;
      logic          clear_block;
      logic [FW-1:0] frame;
      logic          fetched;
      logic          evicted;
      logic [VW-1:0] victim_vpage;
      logic          victim_writeback;
   } rsp_type;
endpackage
`default_nettype wire

// ----- src/pfm_page_mem.sv -----
// Page table memory: allocated flag, mapped flag and frame per virtual page.
// Depends on pfm_pkg.
`default_nettype none
module pfm_page_mem (
   input  wire logic                  clock,
   input  wire logic [pfm_pkg::VW-1:0] rd_addr,
   output logic [pfm_pkg::FW+1:0]     rd_data,
   input  wire logic                  wr_en,
   input  wire logic [pfm_pkg::VW-1:0] wr_addr,
   input  wire logic [pfm_pkg::FW+1:0] wr_data
);
   import pfm_pkg::*;
   logic [FW+1:0] mem [VPAGES];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- src/pfm_frame_mem.sv -----
// Frame table memory: owner page and timestamp per frame.
// Depends on pfm_pkg.
`default_nettype none
module pfm_frame_mem (
   input  wire logic                  clock,
   input  wire logic [pfm_pkg::FW-1:0] rd_addr,
   output logic [pfm_pkg::VW+31:0]    rd_data,
   input  wire logic                  wr_en,
   input  wire logic [pfm_pkg::FW-1:0] wr_addr,
   input  wire logic [pfm_pkg::VW+31:0] wr_data
);
   import pfm_pkg::*;
   logic [VW+31:0] mem [FRAMES];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- src/paging_frame_manager_unit.sv -----
// Top level of the paging frame manager: sequencer, page and frame memories, result register.
// Depends on pfm_pkg, pfm_page_mem and pfm_frame_mem.
`default_nettype none
// One request is taken at a time. After reset a clearing pass sweeps the page
// table, during which no request is taken. Allocate scans the page table one
// entry at a time, reading each entry and then checking it. Make-resident on an
// unmapped page scans the frame table one frame at a time. Each memory has a
// single read port. A result waits in an output register and is held while
// rsp_stall is high.
module paging_frame_manager_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [9:0]  req_vpage,
   input  wire logic        req_dirty,
   input  wire logic [31:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [9:0]       rsp_vpage_out,
   output logic             rsp_clear_block,
   output logic [5:0]       rsp_frame,
   output logic             rsp_fetched,
   output logic             rsp_evicted,
   output logic [9:0]       rsp_victim_vpage,
   output logic             rsp_victim_writeback,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_data
);
   import pfm_pkg::*;
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ARD   = 4'd2;
   localparam logic [3:0] S_ACHK  = 4'd3;
   localparam logic [3:0] S_PRD   = 4'd4;
   localparam logic [3:0] S_PCHK  = 4'd5;
   localparam logic [3:0] S_SCAN  = 4'd6;
   localparam logic [3:0] S_SCHK  = 4'd7;
   localparam logic [3:0] S_VRD   = 4'd8;
   localparam logic [3:0] S_VCHK  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [6:0]    frames_ff, frames_in;
   logic [10:0]   vpages_ff, vpages_in;
   logic [1:0]    op_ff, op_in;
   logic [VW-1:0] vp_ff, vp_in;
   logic          dirty_ff, dirty_in;
   logic [31:0]   now_ff, now_in;
   logic [VW:0]   cnt_ff, cnt_in;
   logic [FW:0]   fi_ff, fi_in;
   logic [FW-1:0] old_ff, old_in;
   logic [31:0]   oldt_ff, oldt_in;
   logic          have_ff, have_in;
   logic [FRAMES-1:0] busy_ff, busy_in, fdirty_ff, fdirty_in;
   logic          ovalid_ff, ovalid_in;
   rsp_type       out_ff, out_in;

   logic [VW-1:0] prd_addr, pwr_addr;
   logic [FW+1:0] prd_data, pwr_data;
   logic          pwr_en;
   logic [FW-1:0] frd_addr, fwr_addr;
   logic [VW+31:0] frd_data, fwr_data;
   logic          fwr_en;

   pfm_page_mem u_page (.clock, .rd_addr(prd_addr), .rd_data(prd_data),
      .wr_en(pwr_en), .wr_addr(pwr_addr), .wr_data(pwr_data));
   pfm_frame_mem u_frame (.clock, .rd_addr(frd_addr), .rd_data(frd_data),
      .wr_en(fwr_en), .wr_addr(fwr_addr), .wr_data(fwr_data));

   logic [VW:0] nv;
   logic [FW:0] nf;
   logic        p_alloc, p_map;
   logic [FW-1:0] p_frame;
   logic [VW-1:0] f_owner;
   logic [31:0]   f_stamp;
   logic [FW-1:0] fi_lo;
   rsp_type       r;

   assign nv = (vpages_ff > 11'(VPAGES)) ? (VW+1)'(VPAGES) : vpages_ff[VW:0];
   assign nf = (frames_ff > 7'(FRAMES)) ? (FW+1)'(FRAMES) : frames_ff[FW:0];
   assign p_alloc = prd_data[FW+1];
   assign p_map   = prd_data[FW];
   assign p_frame = prd_data[FW-1:0];
   assign f_owner = frd_data[VW+31:32];
   assign f_stamp = frd_data[31:0];
   assign fi_lo   = fi_ff[FW-1:0];

   assign req_stall = !(state_ff == S_IDLE) || ovalid_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      frames_in = frames_ff;
      vpages_in = vpages_ff;
      op_in = op_ff; vp_in = vp_ff; dirty_in = dirty_ff; now_in = now_ff;
      cnt_in = cnt_ff; fi_in = fi_ff; old_in = old_ff; oldt_in = oldt_ff;
      have_in = have_ff; busy_in = busy_ff; fdirty_in = fdirty_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      out_in = out_ff;
      r = '0;
      prd_addr = vp_ff; pwr_en = 1'b0; pwr_addr = vp_ff; pwr_data = '0;
      frd_addr = fi_lo; fwr_en = 1'b0; fwr_addr = fi_lo;
      fwr_data = {vp_ff, now_ff};
      if (csr_valid) begin
         if (csr_index == CSR_FRAMES) frames_in = csr_data[6:0];
         else vpages_in = csr_data;
      end
      case (state_ff)
         S_CLEAR: begin
            pwr_en = 1'b1;
            pwr_addr = cnt_ff[VW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (VW+1)'(VPAGES-1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               op_in = req_op; vp_in = req_vpage; dirty_in = req_dirty;
               now_in = req_now; cnt_in = '0; fi_in = '0; have_in = 1'b0;
               if (req_op == OP_ALLOC) state_in = S_ARD;
               else state_in = S_PRD;
            end
         end
         S_ARD: begin
            prd_addr = cnt_ff[VW-1:0];
            if (cnt_ff >= nv) begin
               out_in = '0; out_in.status = ST_NO_PAGE; state_in = S_DONE;
            end else begin
               state_in = S_ACHK;
            end
         end
         S_ACHK: begin
            if (!p_alloc) begin
               pwr_en = 1'b1; pwr_addr = cnt_ff[VW-1:0];
               pwr_data = {1'b1, 1'b0, p_frame};
               r.vpage_out = cnt_ff[VW-1:0]; r.clear_block = 1'b1;
               out_in = r; state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1; state_in = S_ARD;
            end
         end
         S_PRD: begin
            if ({1'b0, vp_ff} >= nv) begin
               out_in = '0; out_in.status = ST_INVALID; state_in = S_DONE;
            end else begin
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            state_in = S_DONE;
            if (!p_alloc) begin
               r.status = ST_INVALID;
            end else if (op_ff == OP_FREE) begin
               if (p_map) busy_in[p_frame] = 1'b0;
               pwr_en = 1'b1; pwr_data = '0;
            end else if (op_ff == OP_MODIFY) begin
               if (!p_map || !busy_ff[p_frame] || fdirty_ff[p_frame]) begin
                  r.status = ST_INVALID;
               end else begin
                  fdirty_in[p_frame] = 1'b1;
                  fwr_en = 1'b1; fwr_addr = p_frame;
                  state_in = S_VRD;
               end
               r.frame = p_map ? p_frame : '0;
               if (r.status != ST_OK) r.frame = '0;
            end else if (p_map) begin
               fdirty_in[p_frame] = dirty_ff;
               old_in = p_frame;
               state_in = S_VRD;
               r.frame = p_frame;
            end else begin
               state_in = S_SCAN;
            end
            out_in = r;
         end
         S_SCAN: begin
            if (fi_ff >= nf) begin
               if (!have_ff) begin
                  out_in = '0; out_in.status = ST_NO_FRAME; state_in = S_DONE;
               end else begin
                  frd_addr = old_ff; state_in = S_VCHK;
               end
            end else if (!busy_ff[fi_lo]) begin
               old_in = fi_lo;
               r.frame = fi_lo; r.fetched = 1'b1; out_in = r;
               busy_in[fi_lo] = 1'b1; fdirty_in[fi_lo] = dirty_ff;
               fwr_en = 1'b1; fwr_addr = fi_lo;
               pwr_en = 1'b1; pwr_data = {1'b1, 1'b1, fi_lo};
               state_in = S_DONE;
            end else begin
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (!have_ff || f_stamp < oldt_ff) begin
               have_in = 1'b1; old_in = fi_lo; oldt_in = f_stamp;
            end
            fi_in = fi_ff + 1'b1;
            frd_addr = fi_lo + 1'b1;
            state_in = S_SCAN;
         end
         S_VCHK: begin
            r.frame = old_ff; r.fetched = 1'b1; r.evicted = 1'b1;
            r.victim_vpage = f_owner; r.victim_writeback = fdirty_ff[old_ff];
            out_in = r;
            fdirty_in[old_ff] = dirty_ff;
            fwr_en = 1'b1; fwr_addr = old_ff;
            pwr_en = 1'b1; pwr_addr = f_owner; pwr_data = {1'b1, 1'b0, old_ff};
            state_in = S_VRD;
         end
         S_VRD: begin
            pwr_en = (op_ff == OP_RESIDENT); pwr_data = {1'b1, 1'b1, old_ff};
            if (op_ff == OP_RESIDENT) begin
               fwr_en = 1'b1; fwr_addr = old_ff;
               if (out_ff.evicted == 1'b0) begin
                  frd_addr = old_ff;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            ovalid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The timestamp rewrite of a resident hit keeps the stored owner, which
   // still holds the page, so the owner field is rewritten with the same page.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         frames_ff <= 7'(FRAMES);
         vpages_ff <= 11'(VPAGES);
         cnt_ff <= '0;
         busy_ff <= '0;
         fdirty_ff <= '0;
         ovalid_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         frames_ff <= frames_in;
         vpages_ff <= vpages_in;
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         fdirty_ff <= fdirty_in;
         ovalid_ff <= ovalid_in;
         have_ff <= have_in;
      end
      op_ff <= op_in; vp_ff <= vp_in; dirty_ff <= dirty_in; now_ff <= now_in;
      fi_ff <= fi_in; old_ff <= old_in; oldt_ff <= oldt_in; out_ff <= out_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_status = out_ff.status;
   assign rsp_vpage_out = out_ff.vpage_out;
   assign rsp_clear_block = out_ff.clear_block;
   assign rsp_frame = out_ff.frame;
   assign rsp_fetched = out_ff.fetched;
   assign rsp_evicted = out_ff.evicted;
   assign rsp_victim_vpage = out_ff.victim_vpage;
   assign rsp_victim_writeback = out_ff.victim_writeback;
endmodule
`default_nettype wire

// ----- src/pfm_checker.sv -----
// Port-level checker for the paging frame manager, bound to the top level.
// Depends on pfm_pkg and paging_frame_manager_unit.
`default_nettype none
module pfm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_clear_block,
   input wire logic       rsp_fetched,
   input wire logic       rsp_evicted,
   input wire logic       rsp_victim_writeback
);
   import pfm_pkg::*;
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");
   a_take_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("stall not raised");
   a_evict_fetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (rsp_fetched && rsp_status == ST_OK))
      else $error("eviction without fetch");
   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_victim_writeback) |-> rsp_evicted)
      else $error("write-back without eviction");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
      && $stable(rsp_clear_block))) else $error("stalled result changed");
endmodule

bind paging_frame_manager_unit pfm_checker u_pfm_checker (.clock, .reset, .req_valid,
   .req_stall, .rsp_valid, .rsp_stall, .rsp_status, .rsp_clear_block, .rsp_fetched,
   .rsp_evicted, .rsp_victim_writeback);
`default_nettype wire
